// ===== src/tbs_pkg.sv =====
// Shared types and constants for the texture bilinear sampler.
// No dependencies; every other file of the block imports this package.
package tbs_pkg;

  localparam int MAX_TEXELS_DEF = 4096;
  localparam int MAX_DIM_DEF    = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W     = 17;
  localparam int COORD_FRAC  = 16;
  localparam int TEXEL_IDX_W = 12;
  localparam int CHAN_W      = 8;
  localparam int NUM_CH      = 3;
  localparam int TEXEL_W     = CHAN_W * NUM_CH;
  localparam int CFG_DIM_W   = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int NUM_TAPS    = 4;

  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd2;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam int TAP_00 = 0;
  localparam int TAP_10 = 1;
  localparam int TAP_01 = 2;
  localparam int TAP_11 = 3;

  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] tex_width;
    logic [CFG_DIM_W-1:0] tex_height;
    logic                 filter_mode;
  } tbs_cfg_t;

  typedef struct packed {
    logic                valid;
    logic [NUM_TAPS-1:0] texel_ok;
  } tbs_ctl_t;

endpackage

// ===== src/tbs_addr_gen.sv =====
// Coordinate scaling and texel address generation for the sampler pipeline.
// Depends on tbs_pkg; feeds the texel memory with reads, writes and weights.
module tbs_addr_gen import tbs_pkg::*; #(
  parameter int MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IDX_W     = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbs_cfg_t                       cfg,
  input  logic                           in_take,
  input  logic                           in_kind,
  input  logic [TEXEL_IDX_W-1:0]         in_index,
  input  logic [TEXEL_W-1:0]             in_texel,
  input  logic [COORD_W-1:0]             in_u,
  input  logic [COORD_W-1:0]             in_v,
  output tbs_ctl_t                       req_ctl,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_idx,
  output logic [TEXEL_W-1:0]             wr_data,
  output logic [NUM_TAPS-1:0][IDX_W-1:0] rd_idx,
  output logic [FRAC_BITS-1:0]           frac_x,
  output logic [FRAC_BITS-1:0]           frac_y
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int TX_W   = COORD_W + DIM_W;
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM + MAX_TEXELS + 4096);
  localparam logic [TX_W-1:0] ROUND_HALF = TX_W'(1) << (COORD_FRAC - 1);

  logic [DIM_W-1:0] w_eff, h_eff, wm1, hm1;
  logic             bilinear;

  logic                   s1_valid_r, s1_kind_r;
  logic [TEXEL_IDX_W-1:0] s1_idx_r;
  logic [TEXEL_W-1:0]     s1_texel_r;
  logic [COORD_W-1:0]     s1_u_r, s1_v_r;
  logic [COORD_W-1:0]     u_sat, v_sat;
  logic [TX_W-1:0]        tx_nxt, ty_nxt;

  logic                   s2_valid_r, s2_kind_r;
  logic [TEXEL_IDX_W-1:0] s2_idx_r;
  logic [TEXEL_W-1:0]     s2_texel_r;
  logic [TX_W-1:0]        s2_tx_r, s2_ty_r;
  logic [TX_W-1:0]        txr, tyr;
  logic [DIM_W-1:0]       x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic [DIM_W:0]         x0p, y0p;
  logic [FRAC_BITS-1:0]   fx_nxt, fy_nxt;

  logic                   s3_valid_r, s3_kind_r;
  logic [TEXEL_IDX_W-1:0] s3_idx_r;
  logic [TEXEL_W-1:0]     s3_texel_r;
  logic [DIM_W-1:0]       s3_x0_r, s3_x1_r, s3_y0_r, s3_y1_r;
  logic [FRAC_BITS-1:0]   s3_fx_r, s3_fy_r;
  logic [ADDR_W-1:0]      row0, row1;
  logic [NUM_TAPS-1:0][ADDR_W-1:0] addr;
  logic [NUM_TAPS-1:0]             addr_ok;
  logic [NUM_TAPS-1:0][IDX_W-1:0]  rd_idx_nxt;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   wr_ok;

  tbs_ctl_t                       req_ctl_r;
  logic                           wr_en_r;
  logic [IDX_W-1:0]               wr_idx_r;
  logic [TEXEL_W-1:0]             wr_data_r;
  logic [NUM_TAPS-1:0][IDX_W-1:0] rd_idx_r;
  logic [FRAC_BITS-1:0]           fx_r, fy_r;

  always_comb begin
    if (cfg.tex_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (int'(cfg.tex_width) > MAX_DIM) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(cfg.tex_width);
    end
    if (cfg.tex_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (int'(cfg.tex_height) > MAX_DIM) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(cfg.tex_height);
    end
  end

  assign wm1      = w_eff - DIM_W'(1);
  assign hm1      = h_eff - DIM_W'(1);
  assign bilinear = (cfg.filter_mode == MODE_BILINEAR);

  // Stage 1: input word, coordinate saturation and scaling.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
    if (in_take) begin
      s1_kind_r  <= in_kind;
      s1_idx_r   <= in_index;
      s1_texel_r <= in_texel;
      s1_u_r     <= in_u;
      s1_v_r     <= in_v;
    end
  end

  assign u_sat  = (s1_u_r > COORD_ONE) ? COORD_ONE : s1_u_r;
  assign v_sat  = (s1_v_r > COORD_ONE) ? COORD_ONE : s1_v_r;
  assign tx_nxt = TX_W'(u_sat) * TX_W'(wm1);
  assign ty_nxt = TX_W'(v_sat) * TX_W'(hm1);

  // Stage 2: integer positions, neighbor clamp and fractions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_kind_r  <= s1_kind_r;
    s2_idx_r   <= s1_idx_r;
    s2_texel_r <= s1_texel_r;
    s2_tx_r    <= tx_nxt;
    s2_ty_r    <= ty_nxt;
  end

  assign txr = s2_tx_r + ROUND_HALF;
  assign tyr = s2_ty_r + ROUND_HALF;

  // Nearest mode uses zero fractions and a single texel, which the blend
  // then passes through unchanged.
  always_comb begin
    if (bilinear) begin
      x0_nxt = DIM_W'(s2_tx_r >> COORD_FRAC);
      y0_nxt = DIM_W'(s2_ty_r >> COORD_FRAC);
      fx_nxt = s2_tx_r[COORD_FRAC-1 -: FRAC_BITS];
      fy_nxt = s2_ty_r[COORD_FRAC-1 -: FRAC_BITS];
    end else begin
      x0_nxt = DIM_W'(txr >> COORD_FRAC);
      y0_nxt = DIM_W'(tyr >> COORD_FRAC);
      fx_nxt = '0;
      fy_nxt = '0;
    end
    x0p = {1'b0, x0_nxt} + (DIM_W + 1)'(1);
    y0p = {1'b0, y0_nxt} + (DIM_W + 1)'(1);
    if (!bilinear) begin
      x1_nxt = x0_nxt;
    end else if (x0p < {1'b0, wm1}) begin
      x1_nxt = x0p[DIM_W-1:0];
    end else begin
      x1_nxt = wm1;
    end
    if (!bilinear) begin
      y1_nxt = y0_nxt;
    end else if (y0p < {1'b0, hm1}) begin
      y1_nxt = y0p[DIM_W-1:0];
    end else begin
      y1_nxt = hm1;
    end
  end

  // Stage 3: row-major addresses and range checks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_kind_r  <= s2_kind_r;
    s3_idx_r   <= s2_idx_r;
    s3_texel_r <= s2_texel_r;
    s3_x0_r    <= x0_nxt;
    s3_x1_r    <= x1_nxt;
    s3_y0_r    <= y0_nxt;
    s3_y1_r    <= y1_nxt;
    s3_fx_r    <= fx_nxt;
    s3_fy_r    <= fy_nxt;
  end

  assign row0 = ADDR_W'(s3_y0_r) * ADDR_W'(w_eff);
  assign row1 = ADDR_W'(s3_y1_r) * ADDR_W'(w_eff);

  always_comb begin
    addr[TAP_00] = row0 + ADDR_W'(s3_x0_r);
    addr[TAP_10] = row0 + ADDR_W'(s3_x1_r);
    addr[TAP_01] = row1 + ADDR_W'(s3_x0_r);
    addr[TAP_11] = row1 + ADDR_W'(s3_x1_r);
    for (int t = 0; t < NUM_TAPS; t++) begin
      addr_ok[t]    = (addr[t] < ADDR_W'(MAX_TEXELS));
      rd_idx_nxt[t] = addr_ok[t] ? IDX_W'(addr[t]) : '0;
    end
  end

  assign wr_addr = ADDR_W'(s3_idx_r);
  assign wr_ok   = (wr_addr < ADDR_W'(MAX_TEXELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_ctl_r <= '0;
      wr_en_r   <= 1'b0;
    end else begin
      req_ctl_r.valid    <= s3_valid_r && (s3_kind_r == KIND_SAMPLE);
      req_ctl_r.texel_ok <= addr_ok;
      wr_en_r            <= s3_valid_r && (s3_kind_r == KIND_WRITE) && wr_ok;
    end
    wr_idx_r  <= wr_ok ? IDX_W'(wr_addr) : '0;
    wr_data_r <= s3_texel_r;
    rd_idx_r  <= rd_idx_nxt;
    fx_r      <= s3_fx_r;
    fy_r      <= s3_fy_r;
  end

  assign req_ctl = req_ctl_r;
  assign wr_en   = wr_en_r;
  assign wr_idx  = wr_idx_r;
  assign wr_data = wr_data_r;
  assign rd_idx  = rd_idx_r;
  assign frac_x  = fx_r;
  assign frac_y  = fy_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_x1_r == s3_x0_r) || (s3_x1_r == s3_x0_r + DIM_W'(1)))
    else $error("right neighbor is neither the column itself nor the next one");

  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_r |-> !req_ctl_r.valid)
    else $error("texel write and sample issued in the same cycle");

endmodule

// ===== src/tbs_texel_mem.sv =====
// Texel storage: two copies of the texel memory, each with two read ports.
// Depends on tbs_pkg; reads are registered, and the sideband is registered alongside them.
module tbs_texel_mem import tbs_pkg::*; #(
  parameter int MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IDX_W     = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tbs_ctl_t                         req_ctl,
  input  logic                             wr_en,
  input  logic [IDX_W-1:0]                 wr_idx,
  input  logic [TEXEL_W-1:0]               wr_data,
  input  logic [NUM_TAPS-1:0][IDX_W-1:0]   rd_idx,
  input  logic [FRAC_BITS-1:0]             frac_x,
  input  logic [FRAC_BITS-1:0]             frac_y,
  output tbs_ctl_t                         rsp_ctl,
  output logic [NUM_TAPS-1:0][TEXEL_W-1:0] rd_data,
  output logic [FRAC_BITS-1:0]             rsp_frac_x,
  output logic [FRAC_BITS-1:0]             rsp_frac_y
);

  logic [TEXEL_W-1:0] top_mem [MAX_TEXELS];
  logic [TEXEL_W-1:0] bot_mem [MAX_TEXELS];

  tbs_ctl_t                         rsp_ctl_r;
  logic [NUM_TAPS-1:0][TEXEL_W-1:0] rd_data_r;
  logic [FRAC_BITS-1:0]             fx_r, fy_r;

  // The upper row of a footprint reads one copy, the lower row the other.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_idx] <= wr_data;
      bot_mem[wr_idx] <= wr_data;
    end
    rd_data_r[TAP_00] <= top_mem[rd_idx[TAP_00]];
    rd_data_r[TAP_10] <= top_mem[rd_idx[TAP_10]];
    rd_data_r[TAP_01] <= bot_mem[rd_idx[TAP_01]];
    rd_data_r[TAP_11] <= bot_mem[rd_idx[TAP_11]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_ctl_r <= '0;
    end else begin
      rsp_ctl_r <= req_ctl;
    end
    fx_r <= frac_x;
    fy_r <= frac_y;
  end

  assign rsp_ctl    = rsp_ctl_r;
  assign rd_data    = rd_data_r;
  assign rsp_frac_x = fx_r;
  assign rsp_frac_y = fy_r;

endmodule

// ===== src/tbs_filter.sv =====
// Two-stage bilinear blend of four texels: horizontal, then vertical.
// Depends on tbs_pkg; takes texels and fractions from the texel memory.
module tbs_filter import tbs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tbs_ctl_t                         rsp_ctl,
  input  logic [NUM_TAPS-1:0][TEXEL_W-1:0] texels,
  input  logic [FRAC_BITS-1:0]             frac_x,
  input  logic [FRAC_BITS-1:0]             frac_y,
  output logic                             out_valid,
  output logic [NUM_CH-1:0][CHAN_W-1:0]    out_chan
);

  localparam int H_W = CHAN_W + FRAC_BITS;
  localparam int A_W = CHAN_W + 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [NUM_TAPS-1:0][TEXEL_W-1:0] tex_eff;
  logic [FRAC_BITS:0]               ofx, ofy;
  logic [NUM_CH-1:0][H_W-1:0]       top_nxt, bot_nxt;
  logic [NUM_CH-1:0][CHAN_W-1:0]    chan_nxt;

  logic                       sa_valid_r;
  logic [NUM_CH-1:0][H_W-1:0] sa_top_r, sa_bot_r;
  logic [FRAC_BITS-1:0]       sa_fy_r;

  logic                          out_valid_r;
  logic [NUM_CH-1:0][CHAN_W-1:0] out_chan_r;

  // Texels beyond the store read as black.
  always_comb begin
    for (int t = 0; t < NUM_TAPS; t++) begin
      tex_eff[t] = rsp_ctl.texel_ok[t] ? texels[t] : '0;
    end
  end

  assign ofx = ONE - (FRAC_BITS + 1)'(frac_x);
  assign ofy = ONE - (FRAC_BITS + 1)'(sa_fy_r);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      top_nxt[k] = H_W'((H_W + 1)'(tex_eff[TAP_00][k*CHAN_W +: CHAN_W]) * (H_W + 1)'(ofx)
                      + (H_W + 1)'(tex_eff[TAP_10][k*CHAN_W +: CHAN_W]) * (H_W + 1)'(frac_x));
      bot_nxt[k] = H_W'((H_W + 1)'(tex_eff[TAP_01][k*CHAN_W +: CHAN_W]) * (H_W + 1)'(ofx)
                      + (H_W + 1)'(tex_eff[TAP_11][k*CHAN_W +: CHAN_W]) * (H_W + 1)'(frac_x));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= rsp_ctl.valid;
    end
    sa_top_r <= top_nxt;
    sa_bot_r <= bot_nxt;
    sa_fy_r  <= frac_y;
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      chan_nxt[k] = CHAN_W'((A_W'(sa_top_r[k]) * A_W'(ofy) + A_W'(sa_bot_r[k]) * A_W'(sa_fy_r))
                            >> (2 * FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sa_valid_r;
    end
    out_chan_r <= chan_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_chan  = out_chan_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_ctl.valid && frac_x == '0 && frac_y == '0) |=> ##1
      (out_chan_r == $past(tex_eff[TAP_00], 2)))
    else $error("zero-fraction blend does not return the corner texel");

endmodule

// ===== src/texture_bilinear_sampler.sv =====
// Top level of the RGB888 texture sampler: configuration registers and pipeline.
// Depends on tbs_pkg, tbs_addr_gen, tbs_texel_mem and tbs_filter.
//
//   channel  handshake            payload
//   input    start / busy         in_kind, in_texel_index, in_texel_*, in_coord_u/v
//   result   out_valid strobe     out_red, out_green, out_blue
//   config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word is taken every cycle; busy stays low. A sample's result strobe rises once the
// sample has passed the address generator, the texel memory and the filter;
// texel writes give no result.
// The rate is set by the duplicated texel memory, whose two copies each serve
// two of the four footprint reads per cycle, and by the pipelined arithmetic.
// Reset is synchronous and clears control and configuration; texel contents
// are undefined until written. The result side has no stall.
module texture_bilinear_sampler import tbs_pkg::*; #(
  parameter int MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic [TEXEL_IDX_W-1:0] in_texel_index,
  input  logic [CHAN_W-1:0]      in_texel_red,
  input  logic [CHAN_W-1:0]      in_texel_green,
  input  logic [CHAN_W-1:0]      in_texel_blue,
  input  logic [COORD_W-1:0]     in_coord_u,
  input  logic [COORD_W-1:0]     in_coord_v,
  output logic                   out_valid,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  tbs_cfg_t cfg_r;
  logic     in_take;

  tbs_ctl_t                         req_ctl, rsp_ctl;
  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_idx;
  logic [TEXEL_W-1:0]               wr_data;
  logic [NUM_TAPS-1:0][IDX_W-1:0]   rd_idx;
  logic [FRAC_BITS-1:0]             req_fx, req_fy, rsp_fx, rsp_fy;
  logic [NUM_TAPS-1:0][TEXEL_W-1:0] rd_data;
  logic [NUM_CH-1:0][CHAN_W-1:0]    out_chan;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_width   <= CFG_DIM_W'(64);
      cfg_r.tex_height  <= CFG_DIM_W'(64);
      cfg_r.filter_mode <= MODE_BILINEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:   cfg_r.tex_width   <= cfg_data;
        REG_TEX_HEIGHT:  cfg_r.tex_height  <= cfg_data;
        REG_FILTER_MODE: cfg_r.filter_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbs_addr_gen #(
    .MAX_TEXELS (MAX_TEXELS),
    .MAX_DIM    (MAX_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_addr_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_take  (in_take),
    .in_kind  (in_kind),
    .in_index (in_texel_index),
    .in_texel ({in_texel_red, in_texel_green, in_texel_blue}),
    .in_u     (in_coord_u),
    .in_v     (in_coord_v),
    .req_ctl  (req_ctl),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .rd_idx   (rd_idx),
    .frac_x   (req_fx),
    .frac_y   (req_fy)
  );

  tbs_texel_mem #(
    .MAX_TEXELS (MAX_TEXELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_texel_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ctl    (req_ctl),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .rd_idx     (rd_idx),
    .frac_x     (req_fx),
    .frac_y     (req_fy),
    .rsp_ctl    (rsp_ctl),
    .rd_data    (rd_data),
    .rsp_frac_x (rsp_fx),
    .rsp_frac_y (rsp_fy)
  );

  tbs_filter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_ctl   (rsp_ctl),
    .texels    (rd_data),
    .frac_x    (rsp_fx),
    .frac_y    (rsp_fy),
    .out_valid (out_valid),
    .out_chan  (out_chan)
  );

  assign out_red   = out_chan[CH_RED];
  assign out_green = out_chan[CH_GREEN];
  assign out_blue  = out_chan[CH_BLUE];

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_kind == KIND_SAMPLE, 7))
    else $error("result strobe without a sample accepted seven edges earlier");

endmodule

// ===== bench/texture_bilinear_sampler_tb.sv =====
// Self-checking testbench for texture_bilinear_sampler: preloads the texel store, then drives
// directed and random write and sample words across many texture settings and checks every
// filtered color against its own predictor. Depends on tbs_pkg and the sampler RTL.
`timescale 1ns / 1ps

module texture_bilinear_sampler_tb;
  import tbs_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int MAX_GAP        = 18;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RESULT_WAIT    = 100;
  localparam int STALL_LIMIT    = 1000;
  localparam int PHASE_ITEMS    = 110;
  localparam int PRELOAD_TEXELS = 512;
  localparam int SHORT_DIM      = PRELOAD_TEXELS / MAX_DIM_DEF;
  localparam int MID_DIM        = MAX_DIM_DEF / 2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] texel_color_t;

  typedef struct {
    logic                   kind;
    logic [TEXEL_IDX_W-1:0] index;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic [COORD_W-1:0]     u;
    logic [COORD_W-1:0]     v;
    int unsigned            gap;
  } sampler_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_kind = KIND_WRITE;
  logic [TEXEL_IDX_W-1:0] in_texel_index = '0;
  logic [CHAN_W-1:0]      in_texel_red = '0;
  logic [CHAN_W-1:0]      in_texel_green = '0;
  logic [CHAN_W-1:0]      in_texel_blue = '0;
  logic [COORD_W-1:0]     in_coord_u = '0;
  logic [COORD_W-1:0]     in_coord_v = '0;
  logic                   out_valid;
  logic [CHAN_W-1:0]      out_red;
  logic [CHAN_W-1:0]      out_green;
  logic [CHAN_W-1:0]      out_blue;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_TEX_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sampler_word_t pending_words[$];
  texel_color_t  expected_colors[$];
  logic [TEXEL_W-1:0] texels [MAX_TEXELS_DEF];

  logic [CFG_DIM_W-1:0] cfg_width = 7'd64;
  logic [CFG_DIM_W-1:0] cfg_height = 7'd64;
  logic                 cfg_mode = MODE_BILINEAR;

  sampler_word_t cur_word;
  logic          staged = 1'b0;
  logic          word_taken = 1'b0;
  int unsigned   idle_left = 0;
  logic          idle_on = 1'b1;

  int fail_count = 0;
  int missing_count = 0;
  int quiet_cycles = 0;
  int n_writes = 0;
  int n_bilinear = 0;
  int n_nearest = 0;
  int n_checked = 0;
  int n_reg_writes = 0;

  texture_bilinear_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_texel_index(in_texel_index),
    .in_texel_red(in_texel_red), .in_texel_green(in_texel_green),
    .in_texel_blue(in_texel_blue), .in_coord_u(in_coord_u), .in_coord_v(in_coord_v),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return 32'(MAX_DIM_DEF);
    return 32'(d);
  endfunction

  function automatic logic [TEXEL_W-1:0] stored_texel(input int unsigned addr);
    if (addr >= MAX_TEXELS_DEF) return '0;
    return texels[addr[TEXEL_IDX_W-1:0]];
  endfunction

  function automatic texel_color_t filter_texels(input logic [COORD_W-1:0] cu,
                                                 input logic [COORD_W-1:0] cv);
    int unsigned wd, ht, u, v, tx, ty, xr, yr, x0, y0, x1, y1, addr, last;
    longint unsigned one, fx, fy, acc;
    longint unsigned wt [NUM_TAPS];
    logic [TEXEL_W-1:0] tap [NUM_TAPS];
    texel_color_t color;
    wd = clamp_dim(cfg_width);
    ht = clamp_dim(cfg_height);
    u = 32'((cu > COORD_ONE) ? COORD_ONE : cu);
    v = 32'((cv > COORD_ONE) ? COORD_ONE : cv);
    tx = u * (wd - 1);
    ty = v * (ht - 1);
    if (cfg_mode == MODE_NEAREST) begin
      xr = (tx + 32'h8000) >> COORD_FRAC;
      yr = (ty + 32'h8000) >> COORD_FRAC;
      addr = yr * wd + xr;
      last = wd * ht - 1;
      if (addr > last) addr = last;
      color = stored_texel(addr);
    end else begin
      x0 = tx >> COORD_FRAC;
      y0 = ty >> COORD_FRAC;
      x1 = (x0 + 1 < wd - 1) ? x0 + 1 : wd - 1;
      y1 = (y0 + 1 < ht - 1) ? y0 + 1 : ht - 1;
      one = 64'd1 << FRAC_BITS_DEF;
      fx = longint'(tx & 32'hFFFF) >> (COORD_FRAC - FRAC_BITS_DEF);
      fy = longint'(ty & 32'hFFFF) >> (COORD_FRAC - FRAC_BITS_DEF);
      wt[TAP_00] = (one - fx) * (one - fy);
      wt[TAP_10] = fx * (one - fy);
      wt[TAP_01] = (one - fx) * fy;
      wt[TAP_11] = fx * fy;
      tap[TAP_00] = stored_texel(y0 * wd + x0);
      tap[TAP_10] = stored_texel(y0 * wd + x1);
      tap[TAP_01] = stored_texel(y1 * wd + x0);
      tap[TAP_11] = stored_texel(y1 * wd + x1);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc = 0;
        for (int t = 0; t < NUM_TAPS; t++) begin
          acc += longint'(tap[t][ch*CHAN_W +: CHAN_W]) * wt[t];
        end
        color[ch] = CHAN_W'(acc >> (2 * FRAC_BITS_DEF));
      end
    end
    return color;
  endfunction

  function automatic int unsigned next_gap();
    if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_ONE;
      2: return COORD_W'($urandom_range(COORD_ONE + 1, COORD_MAX));
      3: return COORD_MAX;
      default: return COORD_W'($urandom_range(0, COORD_ONE));
    endcase
  endfunction

  task automatic push_write(input logic [TEXEL_IDX_W-1:0] idx, input logic [TEXEL_W-1:0] rgb,
                            input int unsigned gap);
    sampler_word_t w;
    w.kind = KIND_WRITE;
    w.index = idx;
    {w.red, w.green, w.blue} = rgb;
    w.u = COORD_W'($urandom);
    w.v = COORD_W'($urandom);
    w.gap = gap;
    pending_words.push_back(w);
  endtask

  task automatic push_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    sampler_word_t w;
    w.kind = KIND_SAMPLE;
    w.index = TEXEL_IDX_W'($urandom);
    {w.red, w.green, w.blue} = TEXEL_W'($urandom);
    w.u = u;
    w.v = v;
    w.gap = next_gap();
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    int n;
    while (pending_words.size() > 0 || staged || start) @(posedge clk);
    for (n = 0; n < RESULT_WAIT && expected_colors.size() > 0; n++) @(posedge clk);
    if (expected_colors.size() > 0) begin
      $display("%0t: %0d expected colors never arrived", $time, expected_colors.size());
      missing_count += expected_colors.size();
      expected_colors.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEX_WIDTH:   cfg_width = data;
      REG_TEX_HEIGHT:  cfg_height = data;
      REG_FILTER_MODE: cfg_mode = data[0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_texture(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic mode);
    logic [CFG_DATA_W-1:0] mode_word;
    wait_idle();
    mode_word = CFG_DATA_W'($urandom);
    mode_word[0] = mode;
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    write_reg(REG_FILTER_MODE, mode_word);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_write(TEXEL_IDX_W'($urandom), TEXEL_W'($urandom), next_gap());
      end else begin
        push_sample(rand_coord(), rand_coord());
      end
    end
  endtask

  always @(negedge clk) begin
    logic drive;
    drive = start;
    if (!rst_n) begin
      drive = 1'b0;
    end else begin
      if (start && word_taken) begin
        drive = 1'b0;
        staged = 1'b0;
      end
      if (!drive) begin
        if (!staged && pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          staged = 1'b1;
          idle_left = cur_word.gap;
        end
        if (staged) begin
          if (idle_left > 0) begin
            idle_left--;
          end else begin
            drive = 1'b1;
            in_kind <= cur_word.kind;
            in_texel_index <= cur_word.index;
            in_texel_red <= cur_word.red;
            in_texel_green <= cur_word.green;
            in_texel_blue <= cur_word.blue;
            in_coord_u <= cur_word.u;
            in_coord_v <= cur_word.v;
          end
        end
      end
    end
    start <= drive;
  end

  always @(posedge clk) begin
    word_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      if (in_kind == KIND_SAMPLE) begin
        expected_colors.push_back(filter_texels(in_coord_u, in_coord_v));
        if (cfg_mode == MODE_NEAREST) n_nearest++;
        else n_bilinear++;
      end else begin
        if (in_texel_index < MAX_TEXELS_DEF) begin
          texels[in_texel_index] <= {in_texel_red, in_texel_green, in_texel_blue};
        end
        n_writes++;
      end
    end
  end

  always @(posedge clk) begin
    texel_color_t want;
    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: color mismatch expected none actual %02h %02h %02h",
                 $time, out_red, out_green, out_blue);
        fail_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want[CH_RED] || out_green !== want[CH_GREEN] ||
            out_blue !== want[CH_BLUE]) begin
          $display("%0t: color mismatch expected %02h %02h %02h actual %02h %02h %02h",
                   $time, want[CH_RED], want[CH_GREEN], want[CH_BLUE],
                   out_red, out_green, out_blue);
          fail_count++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_cfg [7][2];
    logic phase_mode [7];
    phase_cfg = '{'{7'd64, 7'd8}, '{7'd1, 7'd1}, '{7'd0, 7'd127}, '{7'd127, 7'd0},
                  '{7'd2, 7'd64}, '{7'd64, 7'd1}, '{7'd65, 7'd2}};
    phase_mode = '{MODE_NEAREST, MODE_BILINEAR, MODE_NEAREST, MODE_BILINEAR,
                   MODE_BILINEAR, MODE_NEAREST, MODE_NEAREST};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every texture below stays inside the preloaded texels or the ones written here.
    for (int i = 0; i < PRELOAD_TEXELS; i++) begin
      push_write(TEXEL_IDX_W'(i), TEXEL_W'($urandom), 0);
    end
    for (int r = MID_DIM - 1; r <= MID_DIM; r++) begin
      for (int c = MID_DIM - 1; c <= MID_DIM; c++) begin
        push_write(TEXEL_IDX_W'(r * MAX_DIM_DEF + c), TEXEL_W'($urandom), 0);
      end
    end
    push_write(TEXEL_IDX_W'((MAX_DIM_DEF - 1) * MAX_DIM_DEF), TEXEL_W'($urandom), 0);
    push_write(TEXEL_IDX_W'((MAX_DIM_DEF - 1) * MAX_DIM_DEF + 1), TEXEL_W'($urandom), 0);

    push_write(0, 24'hFFFFFF, 0);
    push_write(TEXEL_IDX_W'(MAX_TEXELS_DEF - 1), 24'h000000, 0);
    push_write(TEXEL_IDX_W'(MAX_DIM_DEF - 1), 24'hFF00FF, 0);
    push_sample('0, '0);
    push_sample(COORD_ONE, COORD_ONE);
    push_sample(COORD_ONE, '0);
    push_sample('0, COORD_ONE);
    push_sample(COORD_MAX, COORD_MAX);
    push_sample(17'h08000, 17'h08000);
    push_sample(17'h0FFFF, 17'h00001);
    push_write(TEXEL_IDX_W'(MAX_DIM_DEF), 24'h00FF00, 0);
    push_sample(17'h00100, 17'h00100);

    set_texture(7'd3, 7'd3, MODE_NEAREST);
    push_sample(17'h04000, 17'h04000);
    push_sample(17'h03FFF, 17'h03FFF);
    push_sample(17'h0C000, 17'h0BFFF);
    push_sample(COORD_MAX, 17'h04000);

    for (int p = 0; p < 7; p++) begin
      set_texture(phase_cfg[p][0], phase_cfg[p][1], phase_mode[p]);
      random_items(PHASE_ITEMS);
    end
    for (int p = 0; p < 4; p++) begin
      if (p % 2 == 0) begin
        set_texture(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, SHORT_DIM)),
                    1'($urandom));
      end else begin
        set_texture(CFG_DATA_W'($urandom_range(0, SHORT_DIM)), CFG_DATA_W'($urandom),
                    1'($urandom));
      end
      random_items(PHASE_ITEMS);
    end
    wait_idle();

    $display("Covered %0d texel writes and %0d samples (%0d bilinear, %0d nearest),",
             n_writes, n_bilinear + n_nearest, n_bilinear, n_nearest);
    $display("%0d colors checked over %0d register writes.", n_checked, n_reg_writes);
    if (fail_count == 0 && missing_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tbs_pkg.sv
src/tbs_addr_gen.sv
src/tbs_texel_mem.sv
src/tbs_filter.sv
src/texture_bilinear_sampler.sv
bench/texture_bilinear_sampler_tb.sv
